[design/rtig_pkg.sv]
`default_nettype none

package rtig_pkg;

   // Item kinds on the request channel.
   localparam logic [1:0] REQ_TICK   = 2'd0;
   localparam logic [1:0] REQ_STATUS = 2'd1;
   localparam logic [1:0] REQ_HV     = 2'd2;
   localparam logic [1:0] REQ_ACK    = 2'd3;

   // Interrupt priority levels.
   localparam logic [2:0] LEVEL_VINT = 3'd6;
   localparam logic [2:0] LEVEL_HINT = 3'd4;
   localparam logic [2:0] LEVEL_NONE = 3'd7;

   // Configuration register indexes.
   localparam logic [2:0] CSR_WIDE_MODE    = 3'd0;
   localparam logic [2:0] CSR_PAL_TIMING   = 3'd1;
   localparam logic [2:0] CSR_ACTIVE_LINES = 3'd2;
   localparam logic [2:0] CSR_HINT_RELOAD  = 3'd3;
   localparam logic [2:0] CSR_VINT_ENABLE  = 3'd4;
   localparam logic [2:0] CSR_HINT_ENABLE  = 3'd5;

   // Raster geometry.
   localparam logic [9:0] DOTS_WIDE     = 10'd420;
   localparam logic [9:0] DOTS_NARROW   = 10'd342;
   localparam logic [9:0] LINES_NTSC    = 10'd262;
   localparam logic [9:0] LINES_PAL     = 10'd313;
   localparam logic [8:0] SLOW_FIRST    = 9'd390;
   localparam logic [8:0] SLOW_END      = 9'd420;
   localparam logic [8:0] HBLANK_WIDE   = 9'd320;
   localparam logic [8:0] HBLANK_NARROW = 9'd256;
   localparam logic [7:0] ACTIVE_RESET  = 8'd224;

   // Dot costs in master clocks.
   localparam logic [4:0] COST_FAST = 5'd8;
   localparam logic [4:0] COST_SLOW = 5'd10;

   // A tick can complete at most this many dots (residue below the slow dot cost plus the largest tick).
   localparam int DOT_STEPS = 3;

   // Status word bits.
   localparam logic [15:0] STATUS_SET    = 16'h0200;
   localparam logic [15:0] STATUS_VFLAG  = 16'h0080;
   localparam logic [15:0] STATUS_ODD    = 16'h0010;
   localparam logic [15:0] STATUS_VBLANK = 16'h0008;
   localparam logic [15:0] STATUS_HBLANK = 16'h0004;
   localparam logic [15:0] STATUS_PAL    = 16'h0001;

   typedef struct packed {
      logic [1:0] req_type;
      logic [3:0] mclk_ticks;
      logic [2:0] ack_level;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  irq_level;
      logic [15:0] status_word;
      logic [15:0] hv_count;
      logic        render_request;
      logic [8:0]  render_line_index;
   } rsp_payload_type;

   typedef struct packed {
      logic [2:0] reg_index;
      logic [7:0] wr_data;
   } csr_payload_type;

endpackage

`default_nettype wire

[design/rtig_if.sv]
`default_nettype none

// Request channel.
interface rtig_req_if import rtig_pkg::*;;
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// Result channel.
interface rtig_rsp_if import rtig_pkg::*;;
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// Configuration write channel.
interface rtig_csr_if import rtig_pkg::*;;
   logic            valid;
   logic            ready;
   csr_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[design/raster_timing_interrupt_gen.sv]
// Raster timer with vertical and horizontal interrupt logic.
// req_if carries one item per handshake: a tick (adds master clocks and
// advances dots and lines), a status read, an HV counter read, or an
// interrupt acknowledge. Every accepted item yields exactly one result item
// on rsp_if, carrying the interrupt level after the item, the status or HV
// word for reads, and a render request when a visible line completes.
// csr_if writes the configuration registers; it is always ready. It is to be
// written only while no request is outstanding; the block does not enforce this.
// The result is registered: it is in the output register the cycle after
// the item is accepted. Throughput is one item per cycle while the receiver
// takes each result; the timing registers feed the output register through
// three chained dot steps (5-bit subtract, 10-bit compare) and the line update.
// If the receiver stalls, the result is held and req_if.ready drops until it
// is taken; ready is high whenever the output register is empty or draining.
// Synchronous reset clears the dot, line and residue counters, the field
// bit, the line counter and all interrupt flags, and returns the registers
// to their defaults (active lines 224, everything else zero).
`default_nettype none

module raster_timing_interrupt_gen import rtig_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   rtig_req_if.sink   req_if,
   rtig_rsp_if.source rsp_if,
   rtig_csr_if.sink   csr_if
);

   // Configuration registers.
   logic       wide_ff;
   logic       pal_ff;
   logic [7:0] active_ff;
   logic [7:0] reload_ff;
   logic       vint_en_ff;
   logic       hint_en_ff;

   // Timing state.
   logic [4:0] residue_ff, residue_in;
   logic [8:0] dot_ff, dot_in;
   logic [8:0] line_ff, line_in;
   logic       odd_ff, odd_in;
   logic [7:0] line_cnt_ff, line_cnt_in;
   logic       vint_pend_ff, vint_pend_in;
   logic       vint_stat_ff, vint_stat_in;
   logic       hint_pend_ff, hint_pend_in;

   // Output register.
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic req_accept;
   logic csr_accept;

   // Dot stepping chain.
   logic [4:0] res_step [DOT_STEPS+1];
   logic [8:0] dot_step [DOT_STEPS+1];
   logic [DOT_STEPS-1:0] wrap_step;
   logic [9:0] dot_limit;
   logic       line_done;

   // Line update.
   logic [9:0] line_inc;
   logic [9:0] line_limit;
   logic       field_wrap;
   logic [8:0] line_next;
   logic       line_visible;

   assign csr_if.ready = 1'b1;
   assign csr_accept   = csr_if.valid;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_accept   = req_if.valid && req_if.ready;

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff    <= 1'b0;
         pal_ff     <= 1'b0;
         active_ff  <= ACTIVE_RESET;
         reload_ff  <= 8'd0;
         vint_en_ff <= 1'b0;
         hint_en_ff <= 1'b0;
      end else if (csr_accept) begin
         unique case (csr_if.payload.reg_index)
            CSR_WIDE_MODE:    wide_ff    <= csr_if.payload.wr_data[0];
            CSR_PAL_TIMING:   pal_ff     <= csr_if.payload.wr_data[0];
            CSR_ACTIVE_LINES: active_ff  <= csr_if.payload.wr_data;
            CSR_HINT_RELOAD:  reload_ff  <= csr_if.payload.wr_data;
            CSR_VINT_ENABLE:  vint_en_ff <= csr_if.payload.wr_data[0];
            CSR_HINT_ENABLE:  hint_en_ff <= csr_if.payload.wr_data[0];
            default: ;
         endcase
      end
   end

   assign dot_limit   = wide_ff ? DOTS_WIDE : DOTS_NARROW;
   assign res_step[0] = residue_ff + {1'b0, req_if.payload.mclk_ticks};
   assign dot_step[0] = dot_ff;

   // Each step takes one dot out of the residue if the residue covers its cost.
   for (genvar k = 0; k < DOT_STEPS; k++) begin : g_dot
      logic       slow;
      logic [4:0] cost;
      logic       take;
      logic [9:0] dot_inc;

      assign slow = !wide_ff || (dot_step[k] >= SLOW_FIRST && dot_step[k] < SLOW_END);
      assign cost = slow ? COST_SLOW : COST_FAST;
      assign take = res_step[k] >= cost;
      assign dot_inc = {1'b0, dot_step[k]} + 10'd1;
      assign wrap_step[k] = take && (dot_inc >= dot_limit);
      assign res_step[k+1] = take ? (res_step[k] - cost) : res_step[k];
      assign dot_step[k+1] = !take ? dot_step[k] :
                             (wrap_step[k] ? 9'd0 : dot_inc[8:0]);
   end

   // Only one line can complete per tick, so the line update is done once.
   assign line_done    = |wrap_step;
   assign line_inc     = {1'b0, line_ff} + 10'd1;
   assign line_limit   = pal_ff ? LINES_PAL : LINES_NTSC;
   assign field_wrap   = line_inc >= line_limit;
   assign line_next    = field_wrap ? 9'd0 : line_inc[8:0];
   assign line_visible = line_ff < {1'b0, active_ff};

   // Next state and result of the item.
   always_comb begin
      residue_in   = residue_ff;
      dot_in       = dot_ff;
      line_in      = line_ff;
      odd_in       = odd_ff;
      line_cnt_in  = line_cnt_ff;
      vint_pend_in = vint_pend_ff;
      vint_stat_in = vint_stat_ff;
      hint_pend_in = hint_pend_ff;

      rsp_data_in = '0;

      unique case (req_if.payload.req_type)
         REQ_TICK: begin
            residue_in = res_step[DOT_STEPS];
            dot_in     = dot_step[DOT_STEPS];
            if (line_done) begin
               if (line_visible) begin
                  rsp_data_in.render_request    = 1'b1;
                  rsp_data_in.render_line_index = line_ff;
               end
               line_in = line_next;
               if (field_wrap) begin
                  odd_in = !odd_ff;
               end
               // Line events on the line just entered.
               if (line_next == {1'b0, active_ff}) begin
                  vint_pend_in = 1'b1;
                  vint_stat_in = 1'b1;
               end
               if (line_next < {1'b0, active_ff}) begin
                  if (line_cnt_ff == 8'd0) begin
                     hint_pend_in = 1'b1;
                     line_cnt_in  = reload_ff;
                  end else begin
                     line_cnt_in = line_cnt_ff - 8'd1;
                  end
               end
            end
         end
         REQ_STATUS: begin
            rsp_data_in.status_word = STATUS_SET;
            if (pal_ff) begin
               rsp_data_in.status_word = rsp_data_in.status_word | STATUS_PAL;
            end
            if (dot_ff >= (wide_ff ? HBLANK_WIDE : HBLANK_NARROW)) begin
               rsp_data_in.status_word = rsp_data_in.status_word | STATUS_HBLANK;
            end
            if (!line_visible) begin
               rsp_data_in.status_word = rsp_data_in.status_word | STATUS_VBLANK;
            end
            if (odd_ff) begin
               rsp_data_in.status_word = rsp_data_in.status_word | STATUS_ODD;
            end
            if (vint_stat_ff) begin
               rsp_data_in.status_word = rsp_data_in.status_word | STATUS_VFLAG;
            end
            vint_stat_in = 1'b0;
         end
         REQ_HV: begin
            rsp_data_in.hv_count = {line_ff[7:0], dot_ff[8:1]};
         end
         REQ_ACK: begin
            if (req_if.payload.ack_level == LEVEL_VINT) begin
               vint_pend_in = 1'b0;
            end else if (req_if.payload.ack_level == LEVEL_HINT) begin
               hint_pend_in = 1'b0;
            end
         end
         default: ;
      endcase

      // Priority level after the item.
      if (vint_pend_in && vint_en_ff) begin
         rsp_data_in.irq_level = LEVEL_VINT;
      end else if (hint_pend_in && hint_en_ff) begin
         rsp_data_in.irq_level = LEVEL_HINT;
      end else begin
         rsp_data_in.irq_level = LEVEL_NONE;
      end
   end

   // Timing state advances on each accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         residue_ff   <= 5'd0;
         dot_ff       <= 9'd0;
         line_ff      <= 9'd0;
         odd_ff       <= 1'b0;
         line_cnt_ff  <= 8'd0;
         vint_pend_ff <= 1'b0;
         vint_stat_ff <= 1'b0;
         hint_pend_ff <= 1'b0;
      end else if (req_accept) begin
         residue_ff   <= residue_in;
         dot_ff       <= dot_in;
         line_ff      <= line_in;
         odd_ff       <= odd_in;
         line_cnt_ff  <= line_cnt_in;
         vint_pend_ff <= vint_pend_in;
         vint_stat_ff <= vint_stat_in;
         hint_pend_ff <= hint_pend_in;
      end
   end

   // Output register: loads on accept, empties when the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

`default_nettype wire

[tb/raster_timing_checker.sv]
module raster_timing_checker import rtig_pkg::*; (
   input  logic clock,
   input  logic reset,
   rtig_req_if  req_mon,
   rtig_rsp_if  rsp_mon,
   rtig_csr_if  csr_mon,
   output int   mismatch_count,
   output int   results_awaited
);

   // Configuration as last written on the register channel.
   logic       cfg_wide;
   logic       cfg_pal;
   logic [7:0] cfg_active;
   logic [7:0] cfg_reload;
   logic       cfg_vint_en;
   logic       cfg_hint_en;

   // Raster position and interrupt state of the predictor.
   int unsigned mclk_residue;
   int unsigned dot_pos;
   int unsigned line_pos;
   logic        field_odd;
   logic [7:0]  hint_countdown;
   logic        vint_pend;
   logic        vflag;
   logic        hint_pend;

   // Results predicted for accepted items, oldest first.
   rsp_payload_type expected_results[$];

   // Master clocks that the next dot takes; the last thirty dots of a wide line are slow.
   function automatic int unsigned dot_price();
      if (cfg_wide && dot_pos >= SLOW_FIRST && dot_pos < SLOW_END) begin
         return COST_SLOW;
      end
      return cfg_wide ? COST_FAST : COST_SLOW;
   endfunction

   // Events of the line just entered: vertical interrupt at the first blanking line,
   // and the line countdown while the line is still visible.
   function automatic void enter_line();
      if (line_pos == cfg_active) begin
         vint_pend = 1'b1;
         vflag = 1'b1;
      end
      if (line_pos < cfg_active) begin
         if (hint_countdown == 8'd0) begin
            hint_pend = 1'b1;
            hint_countdown = cfg_reload;
         end else begin
            hint_countdown = hint_countdown - 8'd1;
         end
      end
   endfunction

   // Advances the raster by one item and works out the result it yields.
   function automatic rsp_payload_type raster_step(input req_payload_type item);
      rsp_payload_type res;
      int unsigned     price;
      res = '0;
      case (item.req_type)
         REQ_TICK: begin
            mclk_residue += item.mclk_ticks;
            price = dot_price();
            while (mclk_residue >= price) begin
               mclk_residue -= price;
               dot_pos++;
               if (dot_pos >= (cfg_wide ? DOTS_WIDE : DOTS_NARROW)) begin
                  dot_pos = 0;
                  if (line_pos < cfg_active) begin
                     res.render_request = 1'b1;
                     res.render_line_index = 9'(line_pos);
                  end
                  line_pos++;
                  if (line_pos >= (cfg_pal ? LINES_PAL : LINES_NTSC)) begin
                     line_pos = 0;
                     field_odd = ~field_odd;
                  end
                  enter_line();
               end
               price = dot_price();
            end
            mclk_residue = mclk_residue & 32'h1F;
         end
         REQ_STATUS: begin
            res.status_word = STATUS_SET;
            if (cfg_pal) begin
               res.status_word |= STATUS_PAL;
            end
            if (dot_pos >= (cfg_wide ? HBLANK_WIDE : HBLANK_NARROW)) begin
               res.status_word |= STATUS_HBLANK;
            end
            if (line_pos >= cfg_active) begin
               res.status_word |= STATUS_VBLANK;
            end
            if (field_odd) begin
               res.status_word |= STATUS_ODD;
            end
            if (vflag) begin
               res.status_word |= STATUS_VFLAG;
            end
            // Reading the status clears the flag but leaves the interrupt pending.
            vflag = 1'b0;
         end
         REQ_HV: begin
            res.hv_count = {8'(line_pos), 8'(dot_pos >> 1)};
         end
         default: begin
            // An acknowledge of any other level changes nothing.
            if (item.ack_level == LEVEL_VINT) begin
               vint_pend = 1'b0;
            end else if (item.ack_level == LEVEL_HINT) begin
               hint_pend = 1'b0;
            end
         end
      endcase
      if (vint_pend && cfg_vint_en) begin
         res.irq_level = LEVEL_VINT;
      end else if (hint_pend && cfg_hint_en) begin
         res.irq_level = LEVEL_HINT;
      end else begin
         res.irq_level = LEVEL_NONE;
      end
      return res;
   endfunction

   function automatic void check_field(input string field, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
         mismatch_count++;
      end
   endfunction

   // Watch all three channels at the rising edge.
   always @(posedge clock) begin : watch
      rsp_payload_type seen;
      rsp_payload_type want;
      if (reset) begin
         cfg_wide = 1'b0;
         cfg_pal = 1'b0;
         cfg_active = ACTIVE_RESET;
         cfg_reload = 8'd0;
         cfg_vint_en = 1'b0;
         cfg_hint_en = 1'b0;
         mclk_residue = 0;
         dot_pos = 0;
         line_pos = 0;
         field_odd = 1'b0;
         hint_countdown = 8'd0;
         vint_pend = 1'b0;
         vflag = 1'b0;
         hint_pend = 1'b0;
         expected_results.delete();
      end else begin
         // A result is registered after its item is accepted, so compare before predicting.
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = rsp_mon.payload;
            if (expected_results.size() == 0) begin
               $error("result item arrived with no item outstanding");
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               check_field("irq_level", 16'(want.irq_level), 16'(seen.irq_level));
               check_field("status_word", want.status_word, seen.status_word);
               check_field("hv_count", want.hv_count, seen.hv_count);
               check_field("render_request", 16'(want.render_request),
                           16'(seen.render_request));
               check_field("render_line_index", 16'(want.render_line_index),
                           16'(seen.render_line_index));
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.payload.reg_index)
               CSR_WIDE_MODE:    cfg_wide = csr_mon.payload.wr_data[0];
               CSR_PAL_TIMING:   cfg_pal = csr_mon.payload.wr_data[0];
               CSR_ACTIVE_LINES: cfg_active = csr_mon.payload.wr_data;
               CSR_HINT_RELOAD:  cfg_reload = csr_mon.payload.wr_data;
               CSR_VINT_ENABLE:  cfg_vint_en = csr_mon.payload.wr_data[0];
               CSR_HINT_ENABLE:  cfg_hint_en = csr_mon.payload.wr_data[0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_results.push_back(raster_step(req_mon.payload));
         end
      end
      results_awaited = expected_results.size();
   end

endmodule

[tb/raster_timing_interrupt_gen_tb.sv]
module raster_timing_interrupt_gen_tb;
   import rtig_pkg::*;

   // Master clocks in one line; the same in both modes.
   localparam int LINE_CLOCKS = 3420;
   // Dot about 375 of the first wide line: past the narrow line limit.
   localparam longint unsigned MODE_SWITCH_CLOCKS = 3000;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int SETTLE_CYCLES = 4;

   typedef enum int {GAPS_NONE, GAPS_LIGHT, GAPS_HEAVY} gap_style_type;

   logic clock;
   logic reset;

   rtig_req_if req_if();
   rtig_rsp_if rsp_if();
   rtig_csr_if csr_if();

   int              mismatch_count;
   int              results_awaited;
   int              quiet_cycles;
   longint unsigned clocks_fed;
   gap_style_type   src_mode;
   gap_style_type   sink_mode;
   bit              hold_off_req;

   raster_timing_interrupt_gen u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   raster_timing_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_if),
      .rsp_mon         (rsp_if),
      .csr_mon         (csr_if),
      .mismatch_count  (mismatch_count),
      .results_awaited (results_awaited)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap(input gap_style_type mode);
      int roll;
      roll = $urandom_range(0, 99);
      if (mode == GAPS_NONE || (mode == GAPS_LIGHT && roll < 97) ||
          (mode == GAPS_HEAVY && roll < 70)) begin
         return 0;
      end
      if (mode == GAPS_LIGHT || roll < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 40);
   endfunction

   // Mixes ticks with reads and acknowledges; at least half the acknowledges name a real level.
   function automatic req_payload_type random_request(input int tick_pct, input int min_ticks,
                                                      input int max_ticks);
      req_payload_type item;
      item.mclk_ticks = 4'($urandom_range(min_ticks, max_ticks));
      item.ack_level = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 99) < tick_pct) begin
         item.req_type = REQ_TICK;
      end else begin
         case ($urandom_range(0, 3))
            0: item.req_type = REQ_STATUS;
            1: item.req_type = REQ_HV;
            default: begin
               item.req_type = REQ_ACK;
               if ($urandom_range(0, 1) == 1) begin
                  item.ack_level = ($urandom_range(0, 1) == 1) ? LEVEL_VINT : LEVEL_HINT;
               end
            end
         endcase
      end
      return item;
   endfunction

   // Offers one item and waits until the block takes it.
   task automatic put_item(input req_payload_type item);
      int gap;
      gap = pick_gap(src_mode);
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= item;
      do @(posedge clock); while (!req_if.ready);
      if (item.req_type == REQ_TICK) begin
         clocks_fed += item.mclk_ticks;
      end
   endtask

   task automatic csr_write(input logic [2:0] index, input logic [7:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.payload <= '{reg_index: index, wr_data: value};
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic apply_settings(input bit wide, input bit pal, input logic [7:0] active,
                                 input logic [7:0] reload, input bit vint_on,
                                 input bit hint_on);
      csr_write(CSR_WIDE_MODE, {7'd0, wide});
      csr_write(CSR_PAL_TIMING, {7'd0, pal});
      csr_write(CSR_ACTIVE_LINES, active);
      csr_write(CSR_HINT_RELOAD, reload);
      csr_write(CSR_VINT_ENABLE, {7'd0, vint_on});
      csr_write(CSR_HINT_ENABLE, {7'd0, hint_on});
   endtask

   // Stops offering and waits until every result has been taken.
   task automatic drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (results_awaited != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Runs the raster quickly forward with sparse reads and acknowledges.
   task automatic sweep_to(input longint unsigned target);
      src_mode = GAPS_LIGHT;
      sink_mode = GAPS_LIGHT;
      while (clocks_fed < target) put_item(random_request(94, 12, 15));
   endtask

   // Result receiver: random stalls, and one long hold-off when asked.
   initial begin : result_sink
      int stall;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         stall = pick_gap(sink_mode);
         if (hold_off_req) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
            rsp_if.ready <= 1'b1;
         end else if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Ends the run when no channel has moved for too long.
   always @(posedge clock) begin
      if (!reset && ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                     (csr_if.valid && csr_if.ready))) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int directed_ticks[6];
      int count;
      directed_ticks = '{0, 15, 15, 8, 1, 9};
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      csr_if.valid = 1'b0;
      csr_if.payload = '0;
      src_mode = GAPS_NONE;
      sink_mode = GAPS_NONE;
      hold_off_req = 1'b0;
      clocks_fed = 0;
      quiet_cycles = 0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Wide PAL timing from the start, so the raster position follows from clocks fed.
      apply_settings(1'b1, 1'b1, 8'd240, 8'd0, 1'b1, 1'b1);

      // Directed items: reads at reset, every acknowledge level, tick extremes.
      put_item('{req_type: REQ_STATUS, mclk_ticks: 4'd0, ack_level: 3'd0});
      put_item('{req_type: REQ_HV, mclk_ticks: 4'd0, ack_level: 3'd0});
      for (int lvl = 0; lvl < 8; lvl++) begin
         put_item('{req_type: REQ_ACK, mclk_ticks: 4'd0, ack_level: 3'(lvl)});
      end
      foreach (directed_ticks[i]) begin
         put_item('{req_type: REQ_TICK, mclk_ticks: 4'(directed_ticks[i]), ack_level: 3'd0});
      end
      put_item('{req_type: REQ_STATUS, mclk_ticks: 4'd15, ack_level: 3'd7});
      put_item('{req_type: REQ_HV, mclk_ticks: 4'd15, ack_level: 3'd7});

      // To late in the first wide line, then narrow NTSC mid-line.
      sweep_to(MODE_SWITCH_CLOCKS);

      // Random phases over several settings. The first sees the mode change take effect,
      // and with a single visible line the new line raises the vertical interrupt.
      for (int phase = 0; phase < 6; phase++) begin
         drain();
         case (phase)
            0: apply_settings(1'b0, 1'b0, 8'd1, 8'd255, 1'b1, 1'b1);
            1: apply_settings(1'b1, 1'b0, 8'd240, 8'd0, 1'b0, 1'b1);
            2: apply_settings(1'b1, 1'b1, 8'd232, 8'd1, 1'b1, 1'b0);
            3: apply_settings(1'b0, 1'b1, 8'd240, 8'd2, 1'b0, 1'b0);
            4: apply_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              8'($urandom_range(224, 240)), 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            default: apply_settings(1'b0, 1'b0, 8'd224, 8'd0, 1'b1, 1'b1);
         endcase
         src_mode = (phase % 2 == 0 && phase != 0) ? GAPS_HEAVY : GAPS_NONE;
         sink_mode = (phase == 1 || phase == 3) ? GAPS_NONE : GAPS_HEAVY;
         if (phase == 5) begin
            src_mode = GAPS_HEAVY;
            sink_mode = GAPS_LIGHT;
         end
         // The receiver holds off while items keep coming, so the block backs up.
         if (phase == 0) begin
            hold_off_req = 1'b1;
         end
         count = $urandom_range(60, 80);
         repeat (count) put_item(random_request(80, 0, 15));
      end

      // One more line in narrow PAL timing with only a few visible lines.
      drain();
      apply_settings(1'b0, 1'b1, 8'd2, 8'd0, 1'b1, 1'b1);
      sweep_to(clocks_fed + LINE_CLOCKS);

      drain();
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
